@@ hw/rtl/bqfi_pkg.sv @@
// shared types and codes for the byte queue with filter and insert
// no dependencies; imported by the sequencer and the top level
package bqfi_pkg;

  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
  } bqfi_result_t;

endpackage

@@ hw/rtl/bqfi_slot.sv @@
// ring slot unit: (head + offset) mod DEPTH with one compare and subtract
// no dependencies; shared by every address the sequencer issues
module bqfi_slot #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic [AW-1:0] head,
  input  logic [CW-1:0] offset,
  output logic [AW-1:0] slot
);

  localparam int SW = CW + 1;

  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;

  always_comb begin
    sum     = SW'(head) + SW'(offset);
    wrapped = sum - SW'(DEPTH);
    slot    = (sum >= SW'(DEPTH)) ? wrapped[AW-1:0] : sum[AW-1:0];
  end

endmodule

@@ hw/rtl/bqfi_ram.sv @@
// entry store: one address per cycle, write and registered read-first data
// no dependencies; used by the sequencer
module bqfi_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/bqfi_ctrl.sv @@
// command sequencer: walks the store entry by entry for remove and insert,
// a read state then a write state each; depends on bqfi_pkg, bqfi_slot, bqfi_ram
module bqfi_ctrl
  import bqfi_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [CMD_W-1:0]    command,
  input  logic [BYTE_W-1:0]   value,
  input  logic [POS_W-1:0]    position,
  input  logic                out_free,
  output bqfi_result_t        res
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_READ,
    S_RM_RD,
    S_RM_WR,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT
  } state_t;

  state_t              state;
  logic [CMD_W-1:0]    cmd;
  logic [BYTE_W-1:0]   val;
  logic [POS_W-1:0]    pos;
  logic [AW-1:0]       head;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       rd;
  logic [CW-1:0]       wr;

  logic [CW-1:0]       offset;
  logic [AW-1:0]       addr;
  logic                mem_we;
  logic [BYTE_W-1:0]   mem_wdata;
  logic [BYTE_W-1:0]   rdata;

  logic [CW-1:0]       pos_c;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic                full;
  logic                keep;
  logic [CW-1:0]       rd_dec;
  logic [CW-1:0]       rd_inc;
  logic [CW-1:0]       wr_next;
  logic [CW-1:0]       cnt_inc;
  logic [CW-1:0]       cnt_dec;

  bqfi_slot #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_slot (
    .head   (head),
    .offset (offset),
    .slot   (addr)
  );

  bqfi_ram #(.DEPTH(DEPTH), .AW(AW), .DW(BYTE_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (addr),
    .wdata (mem_wdata),
    .rdata (rdata)
  );

  assign req_stall = (state != S_IDLE);

  always_comb begin
    // position drives the read address in S_EXEC already before its range check
    pos_c   = CW'(pos);
    pos_ext = CMP_W'(pos);
    cnt_ext = CMP_W'(cnt);
    full    = (cnt == CW'(DEPTH));
    keep    = (rdata != val);
    rd_dec  = rd - 1'b1;
    rd_inc  = rd + 1'b1;
    wr_next = keep ? (wr + 1'b1) : wr;
    cnt_inc = cnt + 1'b1;
    cnt_dec = cnt - 1'b1;

    offset    = '0;
    mem_we    = 1'b0;
    mem_wdata = val;
    unique case (state)
      S_EXEC: begin
        if (cmd == CMD_PUSH) begin
          offset = cnt;
          mem_we = out_free && !full;
        end else if (cmd == CMD_READ) begin
          offset = pos_c;
        end
      end
      S_POP:     offset = CW'(1);
      S_RM_RD:   offset = rd;
      S_RM_WR: begin
        offset    = wr;
        mem_we    = keep;
        mem_wdata = rdata;
      end
      S_INS_RD:  offset = rd_dec;
      S_INS_WR: begin
        offset    = rd;
        mem_we    = 1'b1;
        mem_wdata = rdata;
      end
      S_INS_PUT: begin
        offset = pos_c;
        mem_we = 1'b1;
      end
      default:   offset = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= '0;
      head  <= '0;
      cnt   <= '0;
    end else begin
      res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd   <= command;
            val   <= value;
            pos   <= position;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            // default finish: ok, no data, count unchanged
            res.valid  <= 1'b1;
            res.status <= ST_OK;
            res.data   <= '0;
            res.count  <= COUNT_W'(cnt);
            state      <= S_IDLE;
            unique case (cmd)
              CMD_PUSH: begin
                if (full) begin
                  res.status <= ST_FULL;
                end else begin
                  cnt       <= cnt_inc;
                  res.count <= COUNT_W'(cnt_inc);
                end
              end
              CMD_POP: begin
                if (cnt == '0) begin
                  res.status <= ST_EMPTY;
                end else begin
                  res.valid <= 1'b0;
                  state     <= S_POP;
                end
              end
              CMD_REMOVE: begin
                if (cnt != '0) begin
                  res.valid <= 1'b0;
                  rd        <= '0;
                  wr        <= '0;
                  state     <= S_RM_RD;
                end
              end
              CMD_INSERT: begin
                if (pos_ext > cnt_ext) begin
                  res.status <= ST_RANGE;
                end else if (full) begin
                  res.status <= ST_FULL;
                end else begin
                  res.valid <= 1'b0;
                  rd        <= cnt;
                  state     <= (pos_ext == cnt_ext) ? S_INS_PUT : S_INS_RD;
                end
              end
              CMD_CLEAR: begin
                cnt       <= '0;
                head      <= '0;
                res.count <= '0;
              end
              CMD_READ: begin
                if (pos_ext >= cnt_ext) begin
                  res.status <= ST_RANGE;
                end else begin
                  res.valid <= 1'b0;
                  state     <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_POP: begin
          head       <= addr;
          cnt        <= cnt_dec;
          res.valid  <= 1'b1;
          res.status <= ST_OK;
          res.data   <= rdata;
          res.count  <= COUNT_W'(cnt_dec);
          state      <= S_IDLE;
        end
        S_READ: begin
          res.valid  <= 1'b1;
          res.status <= ST_OK;
          res.data   <= rdata;
          res.count  <= COUNT_W'(cnt);
          state      <= S_IDLE;
        end
        S_RM_RD: state <= S_RM_WR;
        S_RM_WR: begin
          wr <= wr_next;
          rd <= rd_inc;
          if (rd_inc == cnt) begin
            cnt        <= wr_next;
            res.valid  <= 1'b1;
            res.status <= ST_OK;
            res.data   <= '0;
            res.count  <= COUNT_W'(wr_next);
            state      <= S_IDLE;
          end else begin
            state <= S_RM_RD;
          end
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          rd    <= rd_dec;
          state <= (rd_dec == pos_c) ? S_INS_PUT : S_INS_RD;
        end
        S_INS_PUT: begin
          cnt        <= cnt_inc;
          res.valid  <= 1'b1;
          res.status <= ST_OK;
          res.data   <= '0;
          res.count  <= COUNT_W'(cnt_inc);
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/byte_queue_with_filter_and_insert.sv @@
// top level of the byte queue: sequencer plus the result register
// depends on bqfi_pkg and bqfi_ctrl
//
//   channel   handshake              fields
//   request   req_valid / req_stall  command[2:0] value[7:0] position[6:0]
//   result    rsp_valid / rsp_stall  status[1:0] data[7:0] count[6:0]
//
// one request at a time; the store has a single address per cycle through one
// ring-slot adder, so push, clear and rejected commands finish on execute, pop
// and read add one read-out state, remove and insert a read and write per entry
// reset clears head, count, state and the result valid flags; the store needs no clearing pass
// a finished result waits in the result register and a new request is taken
// meanwhile; execution waits while that register is still held by a stall
module byte_queue_with_filter_and_insert
  import bqfi_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [CMD_W-1:0]    command,
  input  logic [BYTE_W-1:0]   value,
  input  logic [POS_W-1:0]    position,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [BYTE_W-1:0]   data,
  output logic [COUNT_W-1:0]  count
);

  bqfi_result_t res;
  logic         out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  bqfi_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .command   (command),
    .value     (value),
    .position  (position),
    .out_free  (out_free),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (res.valid) begin
        rsp_valid <= 1'b1;
        status    <= res.status;
        data      <= res.data;
        count     <= res.count;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while sequencer idle afterwards");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !rsp_valid)
    else $error("result produced while result register still held");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> data == '0)
    else $error("rejected command returned data");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |-> count == '0)
    else $error("empty status with nonzero count");
`endif

endmodule
